### design/mgrt_pkg.sv
// Shared types and codes for the minimum-gap and range tracker.
// No dependencies; imported by mgrt_span_unit and min_gap_and_range_tracker_top.
package mgrt_pkg;

    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 11;
    localparam int CAP_W = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;
    localparam logic [VALUE_W-1:0] GAP_NONE = 32'hFFFF_FFFF;

    // Item operations
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

    // Configuration register indexes (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // Output of the shared distance/compare unit
    typedef struct packed {
        logic [VALUE_W-1:0] span;
        logic               below_gap;
    } span_res_t;

endpackage

### design/mgrt_span_unit.sv
// Shared distance unit: |a - b| of two signed words, modulo 2^32, and a test
// of that distance against the running gap. Depends on mgrt_pkg.
module mgrt_span_unit
    import mgrt_pkg::*;
(
    input  logic signed [VALUE_W-1:0] a,
    input  logic signed [VALUE_W-1:0] b,
    input  logic        [VALUE_W-1:0] gap,
    output span_res_t                 res
);

    logic a_ge_b;
    logic [VALUE_W-1:0] diff;

    assign a_ge_b = (a >= b);
    // larger minus smaller always fits in 32 unsigned bits
    assign diff = a_ge_b ? (VALUE_W'(a) - VALUE_W'(b)) : (VALUE_W'(b) - VALUE_W'(a));

    always_comb
    begin
        res.span = diff;
        res.below_gap = (diff < gap);
    end

endmodule

### design/min_gap_and_range_tracker_top.sv
// Minimum-gap and range tracker: top level with sequencer, value memory and
// APB capacity register. Depends on mgrt_pkg and mgrt_span_unit.
// Usage:
//   Command channel: drive op/value with start; the transaction is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Result channel: done is high for exactly one cycle with status, count,
//   spans_valid, shortest_span and longest_span. The receiver cannot stall;
//   it must capture the result in that cycle.
//   Sequence: a clear or a rejected add goes from S_CHECK to S_RESULT. An
//   accepted add goes S_CHECK, S_SCAN (skipped when no values are held),
//   S_INSERT, S_RESULT; S_SCAN runs every held value through one shared
//   distance unit, one memory read per cycle. busy falls at the edge that
//   ends done; a new transaction is taken only once the last one has shown
//   its result.
//   Configuration: APB register 0 (byte address 0) is capacity, 11 bits,
//   reset 1024; write it only while busy is low.
//   Reset: rst_n (asynchronous, active low) empties the set, sets the
//   shortest gap to all ones and capacity to 1024. The value memory is not
//   cleared; only entries below the count are ever read.
module min_gap_and_range_tracker_top
    import mgrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic signed [VALUE_W-1:0]    value,
    // result channel
    output logic                         done,
    output logic        [STATUS_W-1:0]   status,
    output logic        [COUNT_W-1:0]    count,
    output logic                         spans_valid,
    output logic        [VALUE_W-1:0]    shortest_span,
    output logic        [VALUE_W-1:0]    longest_span,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [CFG_ADDR_W-1:0] paddr,
    input  logic        [CFG_DATA_W-1:0] pwdata,
    output logic        [CFG_DATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int EXT_W = (CMP_W > COUNT_W) ? CMP_W : COUNT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_INSERT = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                        op_reg, op_next;
    logic signed [VALUE_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic signed [VALUE_W-1:0]   smallest_reg, smallest_next;
    logic signed [VALUE_W-1:0]   largest_reg, largest_next;
    logic [VALUE_W-1:0]          gap_reg, gap_next;
    logic [STATUS_W-1:0]         status_reg, status_next;
    logic [CAP_W-1:0]            capacity_reg, capacity_next;

    logic [VALUE_W-1:0]          mem [MAX_ENTRIES];
    logic signed [VALUE_W-1:0]   rd_data_reg;
    logic                        rd_en;
    logic                        wr_en;
    logic [ADDR_W-1:0]           rd_addr;

    logic                        accept;
    logic                        cfg_write;
    logic                        full;
    logic                        valid;
    logic [EXT_W-1:0]            count_ext;
    logic [CMP_W-1:0]            cap_cmp;

    logic signed [VALUE_W-1:0]   unit_a;
    logic signed [VALUE_W-1:0]   unit_b;
    span_res_t                   unit_res;

    assign accept = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write && (paddr[2] == REG_CAPACITY))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = CFG_DATA_W'(capacity_reg);
        end
    end

    // count >= min(capacity, MAX_ENTRIES)
    assign cap_cmp = CMP_W'(capacity_reg);
    assign count_ext = EXT_W'(count_reg);
    assign full = (count_ext[CMP_W-1:0] >= cap_cmp) ||
                  (count_reg >= CNT_W'(MAX_ENTRIES));

    // ---------------------------------------------------------------
    // Shared distance unit: scan compares in S_SCAN, range in S_RESULT
    // ---------------------------------------------------------------
    always_comb
    begin
        if (state_reg == S_RESULT)
        begin
            unit_a = largest_reg;
            unit_b = smallest_reg;
        end
        else
        begin
            unit_a = val_reg;
            unit_b = rd_data_reg;
        end
    end

    mgrt_span_unit u_span (
        .a   (unit_a),
        .b   (unit_b),
        .gap (gap_reg),
        .res (unit_res)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign rd_addr = idx_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        val_next = val_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        smallest_next = smallest_reg;
        largest_next = largest_reg;
        gap_next = gap_reg;
        status_next = status_reg;
        rd_en = 1'b0;
        wr_en = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = op;
                    val_next = value;
                    idx_next = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    count_next = '0;
                    gap_next = GAP_NONE;
                    status_next = STATUS_CLEARED;
                    state_next = S_RESULT;
                end
                else if (full)
                begin
                    status_next = STATUS_FULL;
                    state_next = S_RESULT;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    // fetch entry 0, compare it next cycle
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds entry idx_reg - 1
                if (unit_res.below_gap)
                begin
                    gap_next = unit_res.span;
                end
                if (idx_reg == count_reg)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_INSERT:
            begin
                wr_en = 1'b1;
                if (count_reg == '0)
                begin
                    smallest_next = val_reg;
                    largest_next = val_reg;
                end
                else
                begin
                    if (val_reg < smallest_reg)
                    begin
                        smallest_next = val_reg;
                    end
                    if (val_reg > largest_reg)
                    begin
                        largest_next = val_reg;
                    end
                end
                count_next = count_reg + 1'b1;
                status_next = STATUS_ADDED;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            smallest_reg <= '0;
            largest_reg <= '0;
            gap_reg <= GAP_NONE;
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            smallest_reg <= smallest_next;
            largest_reg <= largest_next;
            gap_reg <= gap_next;
            capacity_reg <= capacity_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        status_reg <= status_next;
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= VALUE_W'(val_reg);
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Result
    // ---------------------------------------------------------------
    assign valid = (count_reg >= CNT_W'(2));
    assign done = (state_reg == S_RESULT);
    assign status = status_reg;
    assign count = count_ext[COUNT_W-1:0];
    assign spans_valid = valid;
    assign shortest_span = valid ? gap_reg : '0;
    assign longest_span = valid ? unit_res.span : '0;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond memory depth");

    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> $stable(count_reg))
        else $error("rejected add changed the entry count");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && spans_valid) |-> (shortest_span <= longest_span))
        else $error("shortest span exceeds longest span");

endmodule

### tb/min_gap_and_range_tracker_top_tb.sv
// Testbench for min_gap_and_range_tracker_top: directed and random command traffic,
// with an internal predictor of count, status and span results checked on every done.
// Depends on mgrt_pkg and the design sources; no files or arguments are read.
module min_gap_and_range_tracker_top_tb;
    import mgrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRACK_DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_IDLE_RUN = 30;
    localparam int LARGE_SET_ITEMS = 200;
    localparam int RANDOM_PHASE_ITEMS = 89;
    localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                spans_valid;
        logic [VALUE_W-1:0]  shortest_span;
        logic [VALUE_W-1:0]  longest_span;
    } tracker_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         op;
    logic signed [VALUE_W-1:0]    value;
    logic                         done;
    logic        [STATUS_W-1:0]   status;
    logic        [COUNT_W-1:0]    count;
    logic                         spans_valid;
    logic        [VALUE_W-1:0]    shortest_span;
    logic        [VALUE_W-1:0]    longest_span;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic        [CFG_ADDR_W-1:0] paddr;
    logic        [CFG_DATA_W-1:0] pwdata;
    logic        [CFG_DATA_W-1:0] prdata;
    logic                         pready;

    // predictor state
    logic signed [VALUE_W-1:0] held_values [TRACK_DEPTH];
    int unsigned               held_count;
    logic signed [VALUE_W-1:0] low_value;
    logic signed [VALUE_W-1:0] high_value;
    logic        [VALUE_W-1:0] min_gap;
    logic        [CAP_W-1:0]   capacity_setting;

    tracker_result_t expected_results [$];
    int              error_count;
    int              sender_idle_pct;
    bit              start_mirror;
    logic [VALUE_W-1:0] cluster_base;
    int              stall_cycles;

    min_gap_and_range_tracker_top #(
        .MAX_ENTRIES(TRACK_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .value(value),
        .done(done),
        .status(status),
        .count(count),
        .spans_valid(spans_valid),
        .shortest_span(shortest_span),
        .longest_span(longest_span),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // larger minus smaller, modulo 2^32
    function automatic logic [VALUE_W-1:0] span_between(logic signed [VALUE_W-1:0] a,
                                                        logic signed [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] d;
        if (a >= b)
            d = a - b;
        else
            d = b - a;
        return d;
    endfunction

    function automatic int unsigned effective_capacity();
        return (capacity_setting > TRACK_DEPTH) ? TRACK_DEPTH : capacity_setting;
    endfunction

    function automatic tracker_result_t track_item(logic op_i, logic signed [VALUE_W-1:0] v);
        tracker_result_t r;
        logic [VALUE_W-1:0] d;
        int unsigned i;
        if (op_i == OP_CLEAR)
        begin
            held_count = 0;
            min_gap = GAP_NONE;
            r.status = STATUS_CLEARED;
        end
        else if (held_count >= effective_capacity())
        begin
            r.status = STATUS_FULL;
        end
        else
        begin
            for (i = 0; i < held_count; i++)
            begin
                d = span_between(v, held_values[i]);
                if (d < min_gap)
                    min_gap = d;
            end
            if (held_count == 0)
            begin
                low_value = v;
                high_value = v;
            end
            else
            begin
                if (v < low_value)
                    low_value = v;
                if (v > high_value)
                    high_value = v;
            end
            held_values[held_count] = v;
            held_count++;
            r.status = STATUS_ADDED;
        end
        r.count = COUNT_W'(held_count);
        r.spans_valid = (held_count >= 2);
        r.shortest_span = r.spans_valid ? min_gap : '0;
        r.longest_span = r.spans_valid ? span_between(high_value, low_value) : '0;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom();
            4, 5, 6:    v = cluster_base + $urandom_range(15);
            7:
            begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            8:
            begin
                // repeat a held value to force a zero gap
                if (held_count != 0)
                    v = held_values[$urandom_range(held_count - 1)];
                else
                    v = $urandom();
            end
            default: v = $urandom_range(64) - 32;
        endcase
        return v;
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        logic [CAP_W-1:0] c;
        case ($urandom_range(7))
            0: c = 11'd0;
            1: c = 11'd1;
            2: c = 11'd2;
            3, 4: c = CAP_W'($urandom_range(24, 3));
            5: c = CAP_W'($urandom_range(60, 25));
            6: c = 11'd1024;
            default: c = CAP_W'($urandom_range(2047, 1025));
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_item(logic op_i, logic [VALUE_W-1:0] v);
        int gap;
        tracker_result_t predicted;
        start <= 1'b1;
        start_mirror = 1'b1;
        op <= op_i;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = track_item(op_i, v);
        expected_results.insert(expected_results.size(), predicted);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            start_mirror = 1'b0;
            gap = 0;
            do
            begin
                @(posedge clk);
                gap++;
            end
            while (gap < MAX_IDLE_RUN && $urandom_range(99) < sender_idle_pct);
        end
    endtask

    // hold the sender until every outstanding transaction has returned
    task automatic wait_drain();
        if (start_mirror)
        begin
            start <= 1'b0;
            start_mirror = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic read_capacity();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= CAP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(capacity_setting))
            report_mismatch("capacity readback", prdata, 32'(capacity_setting));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_capacity(logic [CFG_DATA_W-1:0] data);
        wait_drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        capacity_setting = data[CAP_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        read_capacity();
    endtask

    task automatic test_value_extremes();
        sender_idle_pct = 0;
        send_item(OP_ADD, 32'h8000_0000);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        send_item(OP_ADD, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h0000_0000);
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
    endtask

    task automatic test_clear_and_small_sets();
        sender_idle_pct = 54;
        send_item(OP_CLEAR, 32'h0000_0000);
        send_item(OP_ADD, 32'd10);
        send_item(OP_CLEAR, 32'h5A5A_A5A5);
        send_item(OP_ADD, -32'sd10);
        send_item(OP_ADD, -32'sd7);
        send_item(OP_ADD, 32'd1000);
    endtask

    task automatic test_capacity_limits();
        sender_idle_pct = 0;
        write_capacity(32'h0000_0000);
        send_item(OP_CLEAR, 32'h0);
        send_item(OP_ADD, 32'd5);
        write_capacity(32'hA5A5_0002);
        send_item(OP_ADD, 32'd100);
        send_item(OP_ADD, 32'd97);
        send_item(OP_ADD, 32'd98);
        // lower the limit below the held count without clearing
        write_capacity(32'h0000_0001);
        send_item(OP_ADD, 32'd99);
        send_item(OP_CLEAR, 32'h0);
        send_item(OP_ADD, 32'd7);
        send_item(OP_ADD, 32'd8);
    endtask

    // build one long scan with no clears in between
    task automatic test_large_set();
        int i;
        sender_idle_pct = 0;
        cluster_base = $urandom();
        // all ones: capacity field 2047 clamps to the memory depth
        write_capacity(32'hFFFF_FFFF);
        send_item(OP_CLEAR, 32'h0);
        for (i = 0; i < LARGE_SET_ITEMS; i++)
            send_item(OP_ADD, pick_value());
        send_item(OP_CLEAR, 32'h0);
    endtask

    task automatic test_random_traffic(int idle_pct, int n_items);
        int i;
        logic op_i;
        sender_idle_pct = idle_pct;
        cluster_base = $urandom();
        for (i = 0; i < n_items; i++)
        begin
            if (i % 36 == 0)
                write_capacity(($urandom() & 32'hFFFF_F800) | 32'(pick_capacity()));
            else if ($urandom_range(39) == 0)
                wait_drain();
            if (held_count >= effective_capacity())
                op_i = ($urandom_range(2) == 0);
            else
                op_i = ($urandom_range(11) == 0);
            send_item(op_i, (op_i == OP_CLEAR) ? $urandom() : pick_value());
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tracker_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'(status), 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (count !== want.count)
                    report_mismatch("count", 32'(count), 32'(want.count));
                if (spans_valid !== want.spans_valid)
                    report_mismatch("spans_valid", 32'(spans_valid), 32'(want.spans_valid));
                if (shortest_span !== want.shortest_span)
                    report_mismatch("shortest_span", shortest_span, want.shortest_span);
                if (longest_span !== want.longest_span)
                    report_mismatch("longest_span", longest_span, want.longest_span);
            end
        end
    end

    // end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("min_gap_and_range_tracker_top verification failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        stall_cycles = 0;
        start_mirror = 1'b0;
        sender_idle_pct = 0;
        held_count = 0;
        low_value = '0;
        high_value = '0;
        min_gap = GAP_NONE;
        capacity_setting = CAPACITY_RESET;
        cluster_base = $urandom();
        rst_n = 1'b0;
        start <= 1'b0;
        op <= OP_ADD;
        value <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_capacity();
        @(posedge clk);

        test_value_extremes();
        test_clear_and_small_sets();
        test_capacity_limits();
        test_large_set();
        test_random_traffic(0, RANDOM_PHASE_ITEMS);
        test_random_traffic(54, RANDOM_PHASE_ITEMS);
        test_random_traffic(0, RANDOM_PHASE_ITEMS);
        test_random_traffic(9, RANDOM_PHASE_ITEMS);

        wait_drain();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("min_gap_and_range_tracker_top verification clean");
        else
            $display("min_gap_and_range_tracker_top verification failed");
        $finish;
    end

endmodule

### sim.f
design/mgrt_pkg.sv
design/mgrt_span_unit.sv
design/min_gap_and_range_tracker_top.sv
tb/min_gap_and_range_tracker_top_tb.sv
